### design/spl_pkg.sv
// Shared constants, codes and port structs of the slot pool allocator.
package spl_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int LINK_W     = IDX_W + 1;
    localparam int TAG_W      = 32;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOT_COUNT);
    localparam logic [TAG_W-1:0]  TAG_RESET = 32'hFFFF_FFFF;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 3'd0,
        FN_FREE    = 3'd1,
        FN_FIND    = 3'd2,
        FN_NEXT    = 3'd3,
        FN_SET_TAG = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_NOT_IN_USE = 2'd3
    } t_status;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [TAG_W-1:0] data;
    } t_tag_wr;

    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic [TAG_W-1:0]  tag;
    } t_rd_rsp;

    function automatic logic is_null(input logic [LINK_W-1:0] l);
        return l >= NULL_LINK;
    endfunction

endpackage

### design/slot_pool_free_used_lists_top.sv
// Slot pool allocator: free list and doubly linked in-use list kept in link memories.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+------------------------------------------
//   in      | i_in_valid   | o_in_stall   | i_func, i_slot, i_from_head, i_tag_value
//   out     | o_out_valid  | i_out_stall  | o_status, o_result_slot
//
// Find and set tag finish in the dispatch state; allocate and free read one slot's links
// and then write links in two states; next tagged reads one in-use slot per step from the
// head or from the slot after a cursor, one link/tag memory read a step.
// One item is in work at a time; the result waits in an output register, so a new
// item is taken while it is still stalled. Reset is synchronous and needs no clearing
// pass: written-entry bits in flip-flops give the next-link and tag reset values.
module slot_pool_free_used_lists_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [spl_pkg::FUNC_W-1:0]     i_func,
    input  logic [spl_pkg::IDX_W-1:0]      i_slot,
    input  logic                           i_from_head,
    input  logic [spl_pkg::TAG_W-1:0]      i_tag_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [spl_pkg::STATUS_W-1:0]   o_status,
    output logic [spl_pkg::IDX_W-1:0]      o_result_slot
);
    import spl_pkg::*;

    typedef enum logic [3:0] {
        SM_IDLE,
        SM_DISP,
        SM_ALLOC_RD,
        SM_ALLOC_WR2,
        SM_FREE_RD,
        SM_FREE_WR2,
        SM_CURSOR,
        SM_WALK,
        SM_RESP
    } t_state;

    t_state               r_state, n_state;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic                 r_from_head, n_from_head;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [LINK_W-1:0]    r_free_head, n_free_head;
    logic [LINK_W-1:0]    r_used_head, n_used_head;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    t_status              r_res_status, n_res_status;
    logic [IDX_W-1:0]     r_res_slot, n_res_slot;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [IDX_W-1:0]     r_out_slot, n_out_slot;

    t_rd_req  rd;
    t_link_wr nl_wr;
    t_link_wr pl_wr;
    t_tag_wr  tg_wr;
    t_rd_rsp  rsp;
    logic     live;

    spl_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_nl_wr (nl_wr),
        .i_pl_wr (pl_wr),
        .i_tg_wr (tg_wr),
        .o_rsp   (rsp)
    );

    assign live = r_in_use[r_slot];

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_slot       = r_slot;
        n_from_head  = r_from_head;
        n_tag        = r_tag;
        n_free_head  = r_free_head;
        n_used_head  = r_used_head;
        n_in_use     = r_in_use;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        rd           = '0;
        nl_wr        = '0;
        pl_wr        = '0;
        tg_wr        = '0;

        case (r_state)
            SM_IDLE: begin
                if (i_in_valid) begin
                    n_func      = i_func;
                    n_slot      = i_slot;
                    n_from_head = i_from_head;
                    n_tag       = i_tag_value;
                    n_state     = SM_DISP;
                end
            end
            SM_DISP: begin
                n_res_status = ST_NOT_FOUND;
                n_res_slot   = '0;
                n_state      = SM_RESP;
                case (r_func)
                    FN_ALLOC: begin
                        if (is_null(r_free_head)) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            rd      = '{en: 1'b1, addr: r_free_head[IDX_W-1:0]};
                            n_state = SM_ALLOC_RD;
                        end
                    end
                    FN_FREE: begin
                        if (!live) begin
                            n_res_status = ST_NOT_IN_USE;
                        end else begin
                            n_in_use[r_slot] = 1'b0;
                            tg_wr   = '{en: 1'b1, addr: r_slot, data: TAG_RESET};
                            rd      = '{en: 1'b1, addr: r_slot};
                            n_state = SM_FREE_RD;
                        end
                    end
                    FN_FIND: begin
                        if (live) begin
                            n_res_status = ST_OK;
                            n_res_slot   = r_slot;
                        end
                    end
                    FN_NEXT: begin
                        if (r_from_head) begin
                            if (!is_null(r_used_head)) begin
                                rd      = '{en: 1'b1, addr: r_used_head[IDX_W-1:0]};
                                n_state = SM_WALK;
                            end
                        end else if (!live) begin
                            n_res_status = ST_NOT_IN_USE;
                        end else begin
                            rd      = '{en: 1'b1, addr: r_slot};
                            n_state = SM_CURSOR;
                        end
                    end
                    FN_SET_TAG: begin
                        if (!live) begin
                            n_res_status = ST_NOT_IN_USE;
                        end else begin
                            tg_wr        = '{en: 1'b1, addr: r_slot, data: r_tag};
                            n_res_status = ST_OK;
                        end
                    end
                    default: begin
                        n_res_status = ST_NOT_FOUND;
                    end
                endcase
            end
            SM_ALLOC_RD: begin
                // Pop the free head and make it the new in-use head.
                nl_wr = '{en: 1'b1, addr: r_cur, data: r_used_head};
                pl_wr = '{en: 1'b1, addr: r_cur, data: NULL_LINK};
                n_free_head     = rsp.next;
                n_in_use[r_cur] = 1'b1;
                n_state         = SM_ALLOC_WR2;
            end
            SM_ALLOC_WR2: begin
                if (!is_null(r_used_head)) begin
                    pl_wr = '{en: 1'b1, addr: r_used_head[IDX_W-1:0],
                              data: LINK_W'(r_cur)};
                end
                n_used_head  = LINK_W'(r_cur);
                n_res_status = ST_OK;
                n_res_slot   = r_cur;
                n_state      = SM_RESP;
            end
            SM_FREE_RD: begin
                // Unlink from the in-use list.
                if (!is_null(rsp.prev)) begin
                    nl_wr = '{en: 1'b1, addr: rsp.prev[IDX_W-1:0], data: rsp.next};
                end
                if (!is_null(rsp.next)) begin
                    pl_wr = '{en: 1'b1, addr: rsp.next[IDX_W-1:0], data: rsp.prev};
                end
                if (r_used_head == LINK_W'(r_slot)) begin
                    n_used_head = rsp.next;
                end
                n_state = SM_FREE_WR2;
            end
            SM_FREE_WR2: begin
                nl_wr = '{en: 1'b1, addr: r_slot, data: r_free_head};
                pl_wr = '{en: 1'b1, addr: r_slot, data: NULL_LINK};
                n_free_head  = LINK_W'(r_slot);
                n_res_status = ST_OK;
                n_res_slot   = '0;
                n_state      = SM_RESP;
            end
            SM_CURSOR: begin
                if (is_null(rsp.next)) begin
                    n_state = SM_RESP;
                end else begin
                    rd      = '{en: 1'b1, addr: rsp.next[IDX_W-1:0]};
                    n_state = SM_WALK;
                end
            end
            SM_WALK: begin
                // Advance one in-use slot per cycle until the tag matches or the list ends.
                if (rsp.tag == r_tag) begin
                    n_res_status = ST_OK;
                    n_res_slot   = r_cur;
                    n_state      = SM_RESP;
                end else if (is_null(rsp.next)) begin
                    n_state = SM_RESP;
                end else begin
                    rd = '{en: 1'b1, addr: rsp.next[IDX_W-1:0]};
                end
            end
            SM_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = SM_IDLE;
                end
            end
            default: begin
                n_state = SM_IDLE;
            end
        endcase

        n_cur = rd.en ? rd.addr : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SM_IDLE;
            r_free_head <= '0;
            r_used_head <= NULL_LINK;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
        end
        r_func       <= n_func;
        r_slot       <= n_slot;
        r_from_head  <= n_from_head;
        r_tag        <= n_tag;
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    assign o_in_stall    = (r_state != SM_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_result_slot = r_out_slot;

`ifndef NO_ASSERTIONS
    a_walk_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SM_WALK) |-> r_in_use[r_cur])
        else $error("tagged walk reached a slot that is not in use");

    a_free_head_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_null(r_free_head) |-> !r_in_use[r_free_head[IDX_W-1:0]])
        else $error("free list head is marked in use");

    a_used_head_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != SM_FREE_RD) && !is_null(r_used_head)
            |-> r_in_use[r_used_head[IDX_W-1:0]])
        else $error("in-use list head is not in use");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken before the first finished");
`endif

endmodule

### design/spl_store.sv
// Link and tag memories with one shared read address and registered read data.
module spl_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spl_pkg::t_rd_req  i_rd,
    input  spl_pkg::t_link_wr i_nl_wr,
    input  spl_pkg::t_link_wr i_pl_wr,
    input  spl_pkg::t_tag_wr  i_tg_wr,
    output spl_pkg::t_rd_rsp  o_rsp
);
    import spl_pkg::*;

    logic [LINK_W-1:0] r_nl_mem [SLOT_COUNT];
    logic [LINK_W-1:0] r_pl_mem [SLOT_COUNT];
    logic [TAG_W-1:0]  r_tg_mem [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] r_nl_vld;
    logic [SLOT_COUNT-1:0] r_tg_vld;

    logic [LINK_W-1:0] r_nl_q;
    logic [LINK_W-1:0] r_pl_q;
    logic [TAG_W-1:0]  r_tg_q;
    logic              r_nl_hit;
    logic              r_tg_hit;
    logic [IDX_W-1:0]  r_addr;

    always_ff @(posedge i_clk) begin
        if (i_nl_wr.en) begin
            r_nl_mem[i_nl_wr.addr] <= i_nl_wr.data;
        end
        if (i_pl_wr.en) begin
            r_pl_mem[i_pl_wr.addr] <= i_pl_wr.data;
        end
        if (i_tg_wr.en) begin
            r_tg_mem[i_tg_wr.addr] <= i_tg_wr.data;
        end
        if (i_rd.en) begin
            r_nl_q   <= r_nl_mem[i_rd.addr];
            r_pl_q   <= r_pl_mem[i_rd.addr];
            r_tg_q   <= r_tg_mem[i_rd.addr];
            r_nl_hit <= r_nl_vld[i_rd.addr];
            r_tg_hit <= r_tg_vld[i_rd.addr];
            r_addr   <= i_rd.addr;
        end
    end

    // Track next-link and tag entries written since reset; the rest read as their reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_vld <= '0;
            r_tg_vld <= '0;
        end else begin
            if (i_nl_wr.en) begin
                r_nl_vld[i_nl_wr.addr] <= 1'b1;
            end
            if (i_tg_wr.en) begin
                r_tg_vld[i_tg_wr.addr] <= 1'b1;
            end
        end
    end

    // Unwritten next links chain to the following slot; the last one lands on null.
    assign o_rsp.next = r_nl_hit ? r_nl_q : (LINK_W'(r_addr) + LINK_W'(1));
    assign o_rsp.prev = r_pl_q;
    assign o_rsp.tag  = r_tg_hit ? r_tg_q : TAG_RESET;

endmodule
